@@ rtl/bmf_pkg.sv @@
// shared constants, types and tables of the box mean filter
package bmf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W    = 8;
  localparam int COORD_W  = 10;
  localparam int CNT_W    = 11;
  localparam int SIZE_W   = 3;
  localparam int SLOT_W   = $clog2(MAX_WINDOW);
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COLSUM_W = PIX_W + $clog2(MAX_WINDOW + 1);
  localparam int WINSUM_W = PIX_W + $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W  = RECIP_SHIFT + 1;
  localparam int PROD_W   = WINSUM_W + RECIP_W;
  localparam int NUM_SPANS  = (MAX_WINDOW + 1) / 2;
  localparam int SPAN_SEL_W = $clog2(NUM_SPANS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 acc;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    addr;
    logic [PIX_W-1:0]     pix;
  } lb_req_t;

  // one column sum for each window radius
  typedef logic [NUM_SPANS-1:0][COLSUM_W-1:0] colsum_set_t;

  // ceil(2^20 / size^2), exact floor for any window sum
  function automatic logic [RECIP_W-1:0] recip_of(input logic [SIZE_W-1:0] size);
    logic [RECIP_W-1:0] r;
    begin
      case (size)
        3'd2:    r = 21'd262144;
        3'd3:    r = 21'd116509;
        3'd4:    r = 21'd65536;
        3'd5:    r = 21'd41944;
        3'd6:    r = 21'd29128;
        3'd7:    r = 21'd21400;
        default: r = 21'd1048576;
      endcase
      return r;
    end
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

@@ rtl/bmf_in_if.sv @@
// pixel input channel of the box mean filter
interface bmf_in_if import bmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

@@ rtl/bmf_out_if.sv @@
// result channel of the box mean filter
interface bmf_out_if import bmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   mean_value;
  logic [COORD_W-1:0] center_row;
  logic [COORD_W-1:0] center_col;
  logic               frame_done;

  modport source (output valid, output mean_value, output center_row,
                  output center_col, output frame_done, input ready);
  modport sink   (input valid, input mean_value, input center_row,
                  input center_col, input frame_done, output ready);
endinterface

@@ rtl/bmf_line_buf.sv @@
// line buffer: one row bank per window row, all read at the same column
module bmf_line_buf import bmf_pkg::*; (
  input  logic                           clk,
  input  lb_req_t                        req,
  output logic [MAX_WINDOW-1:0][PIX_W-1:0] rd_data
);

  for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q_r;

    always_ff @(posedge clk) begin
      if (req.acc) begin
        if (req.slot == SLOT_W'(b)) begin
          mem[req.addr] <= req.pix;
        end
        rd_q_r <= mem[req.addr];
      end
    end

    assign rd_data[b] = rd_q_r;
  end

endmodule

@@ rtl/bmf_col_cell.sv @@
// window cell: holds the column sums of one column and, inside the window, adds one into the passing window sum
module bmf_col_cell import bmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  logic                  in_win,
  input  logic [SPAN_SEL_W-1:0] sel,
  input  colsum_set_t           sum_in,
  output colsum_set_t           sum_out,
  input  logic [WINSUM_W-1:0]   acc_in,
  output logic [WINSUM_W-1:0]   acc_out
);

  colsum_set_t colsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colsum_r <= '0;
    end else if (shift) begin
      colsum_r <= sum_in;
    end
  end

  assign sum_out = colsum_r;
  assign acc_out = acc_in + (in_win ? WINSUM_W'(colsum_r[sel]) : '0);

endmodule

@@ rtl/box_mean_filter_2d.sv @@
// top level of the streaming square box mean filter
// One pixel item is taken per clock. Pixels go into a line buffer of seven row banks
// read at the current column, a row of seven cells holds the column sums of the window,
// and the window sum is scaled by a reciprocal multiply. The whole pipeline holds
// while a result waits on the output. Border positions give no result; configuration is
// to be written only while the block is idle, which the block does not enforce.
module box_mean_filter_2d import bmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bmf_in_if.sink               in_ch,
  bmf_out_if.source            out_ch
);

  // configuration
  logic [SIZE_W-1:0] window_size_r;
  logic [CNT_W-1:0]  image_width_r;
  logic [CNT_W-1:0]  image_height_r;
  logic [SIZE_W-1:0] size_c;
  logic [CNT_W-1:0]  width_c;
  logic [CNT_W-1:0]  height_c;
  logic [SLOT_W-1:0] rad;
  logic [SLOT_W-1:0] span;
  logic [SPAN_SEL_W-1:0] span_sel;

  // position counters
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   pos_row, pos_col, col_p, row_p;
  logic [SLOT_W-1:0]  pos_slot;
  logic               pos_done;

  // pipeline
  logic en, in_acc;
  logic                s1_valid_r;
  logic [PIX_W-1:0]    s1_pix_r;
  logic [COORD_W-1:0]  s1_row_r, s1_col_r;
  logic [SLOT_W-1:0]   s1_slot_r;
  logic                s1_done_r;
  logic                s1_emit;
  logic                s2_valid_r;
  logic [COORD_W-1:0]  s2_row_r, s2_col_r;
  logic                s2_done_r;
  logic                s3_valid_r;
  logic [WINSUM_W-1:0] s3_sum_r;
  logic [COORD_W-1:0]  s3_row_r, s3_col_r;
  logic                s3_done_r;
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_mean_r;
  logic [COORD_W-1:0]  out_row_r, out_col_r;
  logic                out_done_r;
  logic [PROD_W-1:0]   prod;

  lb_req_t                         lb_req;
  logic [MAX_WINDOW-1:0][PIX_W-1:0] rd_data;
  colsum_set_t                     colsum;
  logic [SLOT_W:0]                 slot_gap;
  colsum_set_t                     cell_sum [MAX_WINDOW];
  logic [WINSUM_W-1:0]             acc [MAX_WINDOW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= SIZE_W'(3);
      image_width_r  <= CNT_W'(MAX_WIDTH);
      image_height_r <= CNT_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  window_size_r  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[CNT_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size_c   = (window_size_r == '0) ? SIZE_W'(1) : window_size_r;
    width_c  = (image_width_r == '0) ? CNT_W'(1) :
               (image_width_r > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : image_width_r;
    height_c = (image_height_r == '0) ? CNT_W'(1) :
               (image_height_r > CNT_W'(MAX_HEIGHT)) ? CNT_W'(MAX_HEIGHT) : image_height_r;
    rad      = (size_c - SIZE_W'(1)) >> 1;
    span     = rad << 1;
    span_sel = rad[SPAN_SEL_W-1:0];
  end

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && en;

  // position of this item and of the next one
  always_comb begin
    pos_row  = CNT_W'(row_r);
    pos_col  = CNT_W'(col_r);
    pos_slot = slot_r;
    if (in_ch.frame_start) begin
      pos_row  = '0;
      pos_col  = '0;
      pos_slot = '0;
    end
    if (pos_col >= width_c) begin
      pos_col  = '0;
      pos_row  = pos_row + CNT_W'(1);
      pos_slot = slot_inc(pos_slot);
    end
    if (pos_row >= height_c) begin
      pos_row  = '0;
      pos_slot = '0;
    end
    pos_done = (pos_row == height_c - CNT_W'(1)) && (pos_col == width_c - CNT_W'(1));
    col_p    = pos_col + CNT_W'(1);
    row_p    = pos_row + CNT_W'(1);
    row_nxt  = pos_row[COORD_W-1:0];
    col_nxt  = col_p[COORD_W-1:0];
    slot_nxt = pos_slot;
    if (col_p >= width_c) begin
      col_nxt = '0;
      if (row_p >= height_c) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_p[COORD_W-1:0];
        slot_nxt = slot_inc(pos_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_comb begin
    lb_req.acc  = in_acc;
    lb_req.slot = pos_slot;
    lb_req.addr = pos_col[ADDR_W-1:0];
    lb_req.pix  = in_ch.pixel_value;
  end

  bmf_line_buf u_line_buf (
    .clk     (clk),
    .req     (lb_req),
    .rd_data (rd_data)
  );

  // column sums for each window radius over the rows ending at the current row
  always_comb begin
    for (int j = 0; j < NUM_SPANS; j++) begin
      colsum[j] = COLSUM_W'(s1_pix_r);
    end
    slot_gap = '0;
    for (int b = 0; b < MAX_WINDOW; b++) begin
      if (s1_slot_r >= SLOT_W'(b)) begin
        slot_gap = {1'b0, s1_slot_r} - (SLOT_W+1)'(b);
      end else begin
        slot_gap = {1'b0, s1_slot_r} + (SLOT_W+1)'(MAX_WINDOW - b);
      end
      for (int j = 1; j < NUM_SPANS; j++) begin
        if (slot_gap != '0 && slot_gap <= (SLOT_W+1)'(2 * j)) begin
          colsum[j] = colsum[j] + COLSUM_W'(rd_data[b]);
        end
      end
    end
  end

  assign s1_emit = (s1_row_r >= COORD_W'(span)) && (s1_col_r >= COORD_W'(span));

  assign acc[0] = '0;
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    colsum_set_t sum_in;
    if (i == 0) begin : g_head
      assign sum_in = colsum;
    end else begin : g_link
      assign sum_in = cell_sum[i-1];
    end
    bmf_col_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (en && s1_valid_r),
      .in_win  (SLOT_W'(i) <= span),
      .sel     (span_sel),
      .sum_in  (sum_in),
      .sum_out (cell_sum[i]),
      .acc_in  (acc[i]),
      .acc_out (acc[i+1])
    );
  end

  assign prod = PROD_W'(s3_sum_r) * PROD_W'(recip_of(size_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_acc;
      s2_valid_r  <= s1_valid_r && s1_emit;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_ch.pixel_value;
      s1_row_r  <= pos_row[COORD_W-1:0];
      s1_col_r  <= pos_col[COORD_W-1:0];
      s1_slot_r <= pos_slot;
      s1_done_r <= pos_done;
    end
    if (en && s1_valid_r) begin
      s2_row_r  <= s1_row_r - COORD_W'(rad);
      s2_col_r  <= s1_col_r - COORD_W'(rad);
      s2_done_r <= s1_done_r;
    end
    if (en && s2_valid_r) begin
      s3_sum_r  <= acc[MAX_WINDOW];
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_done_r <= s2_done_r;
    end
    if (en && s3_valid_r) begin
      out_mean_r <= prod[RECIP_SHIFT +: PIX_W];
      out_row_r  <= s3_row_r;
      out_col_r  <= s3_col_r;
      out_done_r <= s3_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mean_value = out_mean_r;
  assign out_ch.center_row = out_row_r;
  assign out_ch.center_col = out_col_r;
  assign out_ch.frame_done = out_done_r;

endmodule
